// ===== src/lsharp_pkg.sv =====
// lsharp_pkg: shared types and constants for the 3x3 laplacian sharpening block
// holds request/response payload structs, config indexes and reset values
// no dependencies
package lsharp_pkg;

    // line store geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 8;
    localparam int ADDR_BITS  = $clog2(MAX_WIDTH);

    // configuration register widths
    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 12;
    localparam int MASK_BITS     = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    // compare width for column and width values
    localparam int WCMP_BITS = (ADDR_BITS + 1 > CFG_W_BITS) ? ADDR_BITS + 1 : CFG_W_BITS;

    // bounds of the used frame size
    localparam int MIN_SIZE   = 3;
    localparam int MAX_HEIGHT = 4095;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MASK_TOP     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MASK_MIDDLE  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MASK_BOTTOM  = 3'd4;

    // configuration reset values (8-neighbor mask)
    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET     = 11'd512;
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET    = 12'd512;
    localparam logic [MASK_BITS-1:0]  MASK_EDGE_RESET = 24'hFFFFFF;
    localparam logic [MASK_BITS-1:0]  MASK_MID_RESET  = 24'hFF08FF;

    // request action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // input request payload
    typedef struct packed {
        logic                  action;
        logic [PIXEL_BITS-1:0] pixel_in;
    } t_pix_req;

    // output payload
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_out;
        logic                  frame_last;
    } t_pix_rsp;

    // per-item control carried down the pipeline
    typedef struct packed {
        logic border;
        logic last;
    } t_item_ctl;

endpackage

// ===== src/laplacian_sharpen_3x3.sv =====
// laplacian_sharpen_3x3: 3x3 laplacian sharpening over a raster pixel stream
// two line store memories, 3x3 window and a registered multiply/sum pipeline
// depends on lsharp_pkg
// an accepted request moves through stage 1, window, products, row sums and the output register
// throughput: one request per cycle while the output is not stalled; the line stores are read
//   on acceptance, written back from stage 1, forwarding when consecutive requests share a column
// reset (synchronous, active low) clears counters, window, pipeline valids and config;
//   line store contents are not cleared
module laplacian_sharpen_3x3
    import lsharp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_pix_req                 i_in_req,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_pix_rsp                 o_out_rsp,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // configuration registers
    logic [CFG_W_BITS-1:0] r_width;
    logic [CFG_H_BITS-1:0] r_height;
    logic [MASK_BITS-1:0]  r_mask [3];

    // position counters
    logic [ADDR_BITS-1:0]  r_col, n_col;
    logic [CFG_H_BITS-1:0] r_row, n_row;
    logic [ADDR_BITS:0]    r_drain, n_drain;

    // line stores
    logic [PIXEL_BITS-1:0] r_mem_up [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_mem_lo [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_rd_up, r_rd_lo;

    // stage 1: read data arrives
    logic                  r_s1_valid;
    logic [ADDR_BITS-1:0]  r_s1_idx;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic                  r_s1_prod;
    t_item_ctl             r_s1_ctl;

    // forwarding of the write made at the read edge
    logic                  r_fw_en;
    logic [ADDR_BITS-1:0]  r_fw_idx;
    logic [PIXEL_BITS-1:0] r_fw_up, r_fw_lo;

    // stage 2: window
    logic [PIXEL_BITS-1:0] r_win [3][3];
    logic                  r_s2_valid;
    t_item_ctl             r_s2_ctl;

    // stage 3: products
    logic signed [16:0]    r_s3_prod [9];
    logic [PIXEL_BITS-1:0] r_s3_center;
    logic                  r_s3_valid;
    t_item_ctl             r_s3_ctl;

    // stage 4: row sums
    logic signed [18:0]    r_s4_row [3];
    logic [PIXEL_BITS-1:0] r_s4_center;
    logic                  r_s4_valid;
    t_item_ctl             r_s4_ctl;

    // output register
    logic                  r_out_valid;
    t_pix_rsp              r_out_rsp;

    logic                  adv;
    logic                  accept;
    logic [WCMP_BITS-1:0]  w_eff;
    logic [CFG_H_BITS-1:0] h_eff;
    logic [WCMP_BITS-1:0]  col_ext, col_inc, drain_ext;
    logic                  s0_ok;
    logic                  s0_prod;
    t_item_ctl             s0_ctl;
    logic [ADDR_BITS-1:0]  s0_idx;
    logic [PIXEL_BITS-1:0] s0_px;
    logic [PIXEL_BITS-1:0] up_f, lo_f;
    logic signed [16:0]    prod [9];
    logic signed [20:0]    sum_all;
    logic [PIXEL_BITS-1:0] sat;
    logic [PIXEL_BITS:0]   total;
    logic [PIXEL_BITS-1:0] sharp;

    // whole pipeline moves when the output register can take a new value
    assign adv         = !r_out_valid || i_out_ready;
    assign o_in_ready  = adv;
    assign accept      = i_in_valid && adv;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
            r_mask[0] <= MASK_EDGE_RESET;
            r_mask[1] <= MASK_MID_RESET;
            r_mask[2] <= MASK_EDGE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_width   <= i_cfg_data[CFG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_height  <= i_cfg_data[CFG_H_BITS-1:0];
                CFG_MASK_TOP:     r_mask[0] <= i_cfg_data[MASK_BITS-1:0];
                CFG_MASK_MIDDLE:  r_mask[1] <= i_cfg_data[MASK_BITS-1:0];
                CFG_MASK_BOTTOM:  r_mask[2] <= i_cfg_data[MASK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamped frame size
    always_comb begin
        if (WCMP_BITS'(r_width) < WCMP_BITS'(MIN_SIZE)) begin
            w_eff = WCMP_BITS'(MIN_SIZE);
        end else if (WCMP_BITS'(r_width) > WCMP_BITS'(MAX_WIDTH)) begin
            w_eff = WCMP_BITS'(MAX_WIDTH);
        end else begin
            w_eff = WCMP_BITS'(r_width);
        end
        if (r_height < CFG_H_BITS'(MIN_SIZE)) begin
            h_eff = CFG_H_BITS'(MIN_SIZE);
        end else if (r_height > CFG_H_BITS'(MAX_HEIGHT)) begin
            h_eff = CFG_H_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    // request decode and counter update
    always_comb begin
        col_ext   = WCMP_BITS'(r_col);
        col_inc   = col_ext + WCMP_BITS'(1);
        drain_ext = WCMP_BITS'(r_drain);
        n_col     = r_col;
        n_row     = r_row;
        n_drain   = r_drain;
        s0_ok     = 1'b0;
        s0_prod   = 1'b0;
        s0_ctl    = '0;
        s0_idx    = r_col;
        s0_px     = i_in_req.pixel_in;
        if (i_in_req.action == ACT_PIXEL) begin
            s0_ok   = r_row < h_eff;
            s0_prod = (r_col != '0 && r_row != '0) ||
                      (r_col == '0 && r_row >= CFG_H_BITS'(2));
            s0_ctl.border = !(r_row >= CFG_H_BITS'(2) && r_col >= ADDR_BITS'(2) &&
                              col_inc <= w_eff);
            if (col_inc >= w_eff) begin
                n_col = '0;
                n_row = r_row + CFG_H_BITS'(1);
            end else begin
                n_col = col_inc[ADDR_BITS-1:0];
            end
        end else begin
            s0_ok         = r_row >= h_eff;
            s0_prod       = 1'b1;
            s0_ctl.border = 1'b1;
            s0_ctl.last   = drain_ext >= w_eff;
            s0_px         = '0;
            if (s0_ctl.last) begin
                s0_idx  = '0;
                n_col   = '0;
                n_row   = '0;
                n_drain = '0;
            end else begin
                s0_idx  = r_drain[ADDR_BITS-1:0];
                n_drain = r_drain + (ADDR_BITS+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else if (accept && s0_ok) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_drain <= n_drain;
        end
    end

    // forward the value written at the edge this item was read
    always_comb begin
        if (r_fw_en && r_fw_idx == r_s1_idx) begin
            up_f = r_fw_up;
            lo_f = r_fw_lo;
        end else begin
            up_f = r_rd_up;
            lo_f = r_rd_lo;
        end
    end

    // upper line store: read at request, write older lower value back
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_up <= r_mem_up[s0_idx];
            if (r_s1_valid) begin
                r_mem_up[r_s1_idx] <= lo_f;
            end
        end
    end

    // lower line store: read at request, write new pixel back
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_lo <= r_mem_lo[s0_idx];
            if (r_s1_valid) begin
                r_mem_lo[r_s1_idx] <= r_s1_px;
            end
        end
    end

    // stage 1 and forwarding registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fw_en    <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept && s0_ok;
            r_fw_en    <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_idx  <= s0_idx;
            r_s1_px   <= s0_px;
            r_s1_prod <= s0_prod;
            r_s1_ctl  <= s0_ctl;
            r_fw_idx  <= r_s1_idx;
            r_fw_up   <= lo_f;
            r_fw_lo   <= r_s1_px;
        end
    end

    // window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[r][k] <= '0;
                end
            end
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            if (r_s1_valid) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= up_f;
                r_win[1][2] <= lo_f;
                r_win[2][2] <= r_s1_px;
            end
            r_s2_valid <= r_s1_valid && r_s1_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_ctl <= r_s1_ctl;
        end
    end

    // one product per window tap
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                prod[r*3+k] = 17'($signed(r_mask[r][8*k +: 8]) *
                                  $signed({1'b0, r_win[r][k]}));
            end
        end
    end

    // stage 3: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_prod   <= prod;
            r_s3_center <= r_win[1][1];
            r_s3_ctl    <= r_s2_ctl;
        end
    end

    // stage 4: row sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (adv) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                r_s4_row[r] <= 19'(r_s3_prod[r*3]) + 19'(r_s3_prod[r*3+1]) +
                               19'(r_s3_prod[r*3+2]);
            end
            r_s4_center <= r_s3_center;
            r_s4_ctl    <= r_s3_ctl;
        end
    end

    // final sum, clamp to 0..255, add center and saturate
    always_comb begin
        sum_all = 21'(r_s4_row[0]) + 21'(r_s4_row[1]) + 21'(r_s4_row[2]);
        if (sum_all < 0) begin
            sat = '0;
        end else if (sum_all > 21'sd255) begin
            sat = '1;
        end else begin
            sat = sum_all[PIXEL_BITS-1:0];
        end
        total = {1'b0, sat} + {1'b0, r_s4_center};
        sharp = total[PIXEL_BITS] ? '1 : total[PIXEL_BITS-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_rsp.pixel_out  <= r_s4_ctl.border ? r_s4_center : sharp;
            r_out_rsp.frame_last <= r_s4_ctl.last;
        end
    end

endmodule
